// File: sv/assert_macros.svh
// Assertion macros used by the back part of the palette extractor RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define VPE_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("palette extractor assertion failed");

// A consequence that must hold in the same cycle as its cause.
`define VPE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("palette extractor assertion failed");

// A consequence that must hold in the cycle after its cause.
`define VPE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("palette extractor assertion failed");

`endif

// File: sv/vpe_pkg.sv
// Package with the types, constants and state encodings of the palette extractor.
package vpe_pkg;

  localparam int unsigned MAX_PIXELS_DEF   = 65536;
  localparam int unsigned PALETTE_SIZE_DEF = 8;

  localparam int unsigned CFG_DATA_W = 18;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [7:0]  MIN_SAT_RST    = 8'd30;
  localparam logic [7:0]  MIN_BRI_RST    = 8'd50;
  localparam logic [17:0] DIST_LIMIT_RST = 18'd900;
  localparam logic [3:0]  DARK_RST       = 4'd7;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_SAT    = 2'd0,
    CFG_MIN_BRI    = 2'd1,
    CFG_DIST_LIMIT = 2'd2,
    CFG_DARK       = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]  min_sat;
    logic [7:0]  min_bri;
    logic [17:0] dist_limit;
    logic [3:0]  dark_tenths;
  } vpe_cfg_t;

  typedef struct packed {
    logic       keep;
    logic       last;
    logic [7:0] sat;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } vpe_item_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } front_state_e;

  typedef enum logic [3:0] {
    BK_COLLECT,
    BK_NEXT_SAT,
    BK_SCAN_RD,
    BK_SCAN_CHK,
    BK_DIST_RD,
    BK_DIST_SQ,
    BK_DIST_CMP,
    BK_EMIT_RD,
    BK_EMIT_LD
  } back_state_e;

endpackage

// File: sv/vpe_pix_if.sv
// Pixel input channel.
interface vpe_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] pix_blue;
  logic [7:0] pix_green;
  logic [7:0] pix_red;
  logic       last_pixel;

  modport source (output valid, output pix_blue, output pix_green, output pix_red,
                  output last_pixel, input ready);
  modport sink (input valid, input pix_blue, input pix_green, input pix_red,
                input last_pixel, output ready);
endinterface

// File: sv/vpe_pal_if.sv
// Palette result channel.
interface vpe_pal_if;
  logic       valid;
  logic       ready;
  logic [2:0] slot;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] dark_red;
  logic [7:0] dark_green;
  logic [7:0] dark_blue;
  logic [3:0] colors_found;
  logic       last_color;

  modport source (output valid, output slot, output out_red, output out_green,
                  output out_blue, output dark_red, output dark_green, output dark_blue,
                  output colors_found, output last_color, input ready);
  modport sink (input valid, input slot, input out_red, input out_green, input out_blue,
                input dark_red, input dark_green, input dark_blue, input colors_found,
                input last_color, output ready);
endinterface

// File: sv/vibrant_palette_extractor_top.sv
// Top level of the vibrant palette extractor: configuration registers and the two parts.
//
// Pixels enter on the pix channel (valid/ready) with blue, green, red and a last_pixel
// flag. In the front part each pixel is accepted, its saturation is worked out by the
// bit-serial saturation divider and the classified pixel is passed into a two-entry
// queue; a new pixel is accepted only once the last one is in the queue. The back part
// stores kept pixels in a RAM of MAX_PIXELS entries. After the transaction that carries
// last_pixel, the back part scans the stored pixels once for every saturation level
// that occurs, from 255 down, comparing each stored pixel of that level with the palette
// colours and storing it as a new colour only if none lies within dist_limit. The palette
// (up to PALETTE_SIZE colours) is then sent on the pal channel newest first, the last
// one flagged by last_color; an empty palette gives one all-zero result with last_color
// set. Configuration is written through cfg_we_i, cfg_idx_i and cfg_data_i; the user
// must do so only while idle, as the block itself does not enforce it.
// Reset clears the stored pixel count and palette and restores the register defaults.
// A stalled receiver holds the current result; the front part keeps accepting pixels
// of the next image until the queue fills.
module vibrant_palette_extractor_top #(
  parameter int unsigned MAX_PIXELS   = vpe_pkg::MAX_PIXELS_DEF,
  parameter int unsigned PALETTE_SIZE = vpe_pkg::PALETTE_SIZE_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  vpe_pix_if.sink                         pix,
  vpe_pal_if.source                       pal,
  input  logic                            cfg_we_i,
  input  logic [vpe_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [vpe_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import vpe_pkg::*;

  vpe_cfg_t  cfg_q, cfg_d;
  vpe_item_t front_item, queue_item;
  logic      push, full, pop, empty;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_SAT:    cfg_d.min_sat     = cfg_data_i[7:0];
        CFG_MIN_BRI:    cfg_d.min_bri     = cfg_data_i[7:0];
        CFG_DIST_LIMIT: cfg_d.dist_limit  = cfg_data_i[17:0];
        CFG_DARK:       cfg_d.dark_tenths = cfg_data_i[3:0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_sat     <= MIN_SAT_RST;
      cfg_q.min_bri     <= MIN_BRI_RST;
      cfg_q.dist_limit  <= DIST_LIMIT_RST;
      cfg_q.dark_tenths <= DARK_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  vpe_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pix    (pix),
    .cfg_i  (cfg_q),
    .full_i (full),
    .push_o (push),
    .item_o (front_item)
  );

  vpe_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (front_item),
    .full_o  (full),
    .pop_i   (pop),
    .item_o  (queue_item),
    .empty_o (empty)
  );

  vpe_back #(
    .MAX_PIXELS   (MAX_PIXELS),
    .PALETTE_SIZE (PALETTE_SIZE)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_q),
    .empty_i (empty),
    .item_i  (queue_item),
    .pop_o   (pop),
    .pal     (pal)
  );
endmodule

// File: sv/vpe_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vpe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// File: sv/vpe_fifo.sv
// Two-entry queue of classified pixels between the front and back parts.
module vpe_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  vpe_pkg::vpe_item_t item_i,
  output logic              full_o,
  input  logic              pop_i,
  output vpe_pkg::vpe_item_t item_o,
  output logic              empty_o
);
  import vpe_pkg::*;

  vpe_item_t  mem_q [2];
  logic       wptr_q, wptr_d;
  logic       rptr_q, rptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = mem_q[rptr_q];

  always_comb begin
    wptr_d = do_push ? ~wptr_q : wptr_q;
    rptr_d = do_pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end
endmodule

// File: sv/vpe_front.sv
// Front part: accepts pixels, works out saturation with a serial divider and classifies them.
module vpe_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  vpe_pix_if.sink            pix,
  input  vpe_pkg::vpe_cfg_t  cfg_i,
  input  logic               full_i,
  output logic               push_o,
  output vpe_pkg::vpe_item_t item_o
);
  import vpe_pkg::*;

  front_state_e state_q, state_d;
  logic [7:0]  red_q, green_q, blue_q;
  logic        last_q;
  logic [7:0]  mx_q;
  logic [7:0]  num_lo_q;
  logic [8:0]  den_q;
  logic [8:0]  rem_q, rem_d;
  logic [7:0]  quo_q, quo_d;
  logic [2:0]  step_q, step_d;
  logic [7:0]  in_mx, in_mn;
  logic [16:0] in_num;
  logic [9:0]  trial, trial_diff;
  logic        trial_ge;
  logic [7:0]  sat;

  always_comb begin
    in_mx = pix.pix_red;
    in_mn = pix.pix_red;
    if (pix.pix_green > in_mx) in_mx = pix.pix_green;
    if (pix.pix_blue > in_mx) in_mx = pix.pix_blue;
    if (pix.pix_green < in_mn) in_mn = pix.pix_green;
    if (pix.pix_blue < in_mn) in_mn = pix.pix_blue;
    in_num = 17'(17'd510 * 17'(in_mx - in_mn)) + 17'(in_mx);
  end

  assign trial      = {rem_q, num_lo_q[step_q]};
  assign trial_ge   = (trial >= {1'b0, den_q});
  assign trial_diff = trial - {1'b0, den_q};

  // A black pixel has no hue; its saturation is zero.
  assign sat = (mx_q == 8'd0) ? 8'd0 : quo_q;

  always_comb begin
    item_o.keep  = (sat != 8'd0) && (sat >= cfg_i.min_sat) && (mx_q >= cfg_i.min_bri);
    item_o.last  = last_q;
    item_o.sat   = sat;
    item_o.red   = red_q;
    item_o.green = green_q;
    item_o.blue  = blue_q;
  end

  always_comb begin
    state_d   = state_q;
    rem_d     = rem_q;
    quo_d     = quo_q;
    step_d    = step_q;
    pix.ready = 1'b0;
    push_o    = 1'b0;
    unique case (state_q)
      FR_IDLE: begin
        pix.ready = 1'b1;
        if (pix.valid) begin
          rem_d   = in_num[16:8];
          quo_d   = 8'd0;
          step_d  = 3'd7;
          state_d = FR_DIV;
        end
      end
      FR_DIV: begin
        quo_d = {quo_q[6:0], trial_ge};
        rem_d = trial_ge ? trial_diff[8:0] : trial[8:0];
        step_d = step_q - 3'd1;
        if (step_q == 3'd0) begin
          state_d = FR_PUSH;
        end
      end
      FR_PUSH: begin
        push_o = !full_i;
        if (!full_i) begin
          state_d = FR_IDLE;
        end
      end
      default: state_d = FR_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (state_q == FR_IDLE && pix.valid) begin
      red_q    <= pix.pix_red;
      green_q  <= pix.pix_green;
      blue_q   <= pix.pix_blue;
      last_q   <= pix.last_pixel;
      mx_q     <= in_mx;
      num_lo_q <= in_num[7:0];
      den_q    <= {in_mx, 1'b0};
    end
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    step_q <= step_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

// File: sv/vpe_back.sv
// Back part: stores kept pixels, selects distinct colours by saturation and emits the palette.
`include "assert_macros.svh"
module vpe_back #(
  parameter int unsigned MAX_PIXELS   = vpe_pkg::MAX_PIXELS_DEF,
  parameter int unsigned PALETTE_SIZE = vpe_pkg::PALETTE_SIZE_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  vpe_pkg::vpe_cfg_t  cfg_i,
  input  logic               empty_i,
  input  vpe_pkg::vpe_item_t item_i,
  output logic               pop_o,
  vpe_pal_if.source          pal
);
  import vpe_pkg::*;

  localparam int unsigned AW  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned CW  = $clog2(MAX_PIXELS + 1);
  localparam int unsigned PAW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;
  localparam int unsigned PCW = $clog2(PALETTE_SIZE + 1);
  localparam logic [CW-1:0]  MaxCount = CW'(MAX_PIXELS);
  localparam logic [PCW-1:0] PalFull  = PCW'(PALETTE_SIZE);

  function automatic logic [7:0] darken(input logic [7:0] c, input logic [3:0] dt);
    logic [11:0] x;
    logic [24:0] p;
    logic [8:0]  q;
    x = 12'({4'd0, c} * {8'd0, dt});
    // Multiply by 6554/65536 gives floor(x/10) for every product in range.
    p = 25'({13'd0, x} * 25'd6554);
    q = p[24:16];
    return (q > 9'd255) ? 8'd255 : q[7:0];
  endfunction

  back_state_e     state_q, state_d;
  logic [CW-1:0]   count_q, count_d;
  logic [255:0]    present_q, present_d;
  logic [7:0]      sat_q, sat_d;
  logic [CW-1:0]   idx_q, idx_d;
  logic [23:0]     cand_q, cand_d;
  logic [PCW-1:0]  pj_q, pj_d;
  logic [PCW-1:0]  pcount_q, pcount_d;
  logic [PCW-1:0]  k_q, k_d;
  logic [15:0]     sq_r_q, sq_g_q, sq_b_q;
  logic [7:0]      dr, dg, db;
  logic [17:0]     dist_sum;

  logic            out_valid_q, out_valid_d;
  logic [2:0]      slot_q;
  logic [7:0]      out_r_q, out_g_q, out_b_q, dk_r_q, dk_g_q, dk_b_q;
  logic [3:0]      found_q;
  logic            olast_q;
  logic            load;
  logic            load_last;

  logic            kept_we;
  logic [31:0]     kept_rdata;
  logic            pal_we;
  logic [PAW-1:0]  pal_raddr;
  logic [23:0]     pal_rdata;
  logic [PCW-1:0]  emit_idx;

  assign kept_we = (state_q == BK_COLLECT) && !empty_i && item_i.keep &&
                   (count_q < MaxCount);
  assign emit_idx = pcount_q - PCW'(1) - k_q;
  assign pal_raddr = (state_q == BK_EMIT_RD || state_q == BK_EMIT_LD) ?
                     emit_idx[PAW-1:0] : pj_q[PAW-1:0];
  assign pal_we = (state_q == BK_DIST_RD) && (pj_q == pcount_q);

  vpe_ram #(.WIDTH(32), .DEPTH(MAX_PIXELS)) u_kept_ram (
    .clk_i   (clk_i),
    .we_i    (kept_we),
    .waddr_i (count_q[AW-1:0]),
    .wdata_i ({item_i.sat, item_i.red, item_i.green, item_i.blue}),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (kept_rdata)
  );

  vpe_ram #(.WIDTH(24), .DEPTH(PALETTE_SIZE)) u_pal_ram (
    .clk_i   (clk_i),
    .we_i    (pal_we),
    .waddr_i (pcount_q[PAW-1:0]),
    .wdata_i (cand_q),
    .raddr_i (pal_raddr),
    .rdata_o (pal_rdata)
  );

  assign dr   = (pal_rdata[23:16] > cand_q[23:16]) ? pal_rdata[23:16] - cand_q[23:16] :
                                                     cand_q[23:16] - pal_rdata[23:16];
  assign dg   = (pal_rdata[15:8] > cand_q[15:8]) ? pal_rdata[15:8] - cand_q[15:8] :
                                                   cand_q[15:8] - pal_rdata[15:8];
  assign db   = (pal_rdata[7:0] > cand_q[7:0]) ? pal_rdata[7:0] - cand_q[7:0] :
                                                 cand_q[7:0] - pal_rdata[7:0];
  assign dist_sum = 18'(sq_r_q) + 18'(sq_g_q) + 18'(sq_b_q);

  assign load      = (state_q == BK_EMIT_LD) && (!out_valid_q || pal.ready);
  assign load_last = load && ((pcount_q == PCW'(0)) || (k_q == pcount_q - PCW'(1)));

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    present_d = present_q;
    sat_d     = sat_q;
    idx_d     = idx_q;
    cand_d    = cand_q;
    pj_d      = pj_q;
    pcount_d  = pcount_q;
    k_d       = k_q;
    pop_o     = 1'b0;
    unique case (state_q)
      BK_COLLECT: begin
        pop_o = !empty_i;
        if (!empty_i) begin
          if (kept_we) begin
            count_d = count_q + CW'(1);
            present_d[item_i.sat] = 1'b1;
          end
          if (item_i.last) begin
            sat_d   = 8'd255;
            state_d = BK_NEXT_SAT;
          end
        end
      end
      BK_NEXT_SAT: begin
        if (pcount_q == PalFull || sat_q == 8'd0) begin
          k_d     = '0;
          state_d = BK_EMIT_RD;
        end else if (present_q[sat_q]) begin
          idx_d   = '0;
          state_d = BK_SCAN_RD;
        end else begin
          sat_d = sat_q - 8'd1;
        end
      end
      BK_SCAN_RD: begin
        if (pcount_q == PalFull) begin
          state_d = BK_NEXT_SAT;
        end else if (idx_q == count_q) begin
          sat_d   = sat_q - 8'd1;
          state_d = BK_NEXT_SAT;
        end else begin
          state_d = BK_SCAN_CHK;
        end
      end
      BK_SCAN_CHK: begin
        if (kept_rdata[31:24] == sat_q) begin
          cand_d  = kept_rdata[23:0];
          pj_d    = '0;
          state_d = BK_DIST_RD;
        end else begin
          idx_d   = idx_q + CW'(1);
          state_d = BK_SCAN_RD;
        end
      end
      BK_DIST_RD: begin
        if (pj_q == pcount_q) begin
          pcount_d = pcount_q + PCW'(1);
          idx_d    = idx_q + CW'(1);
          state_d  = BK_SCAN_RD;
        end else begin
          state_d = BK_DIST_SQ;
        end
      end
      BK_DIST_SQ: begin
        state_d = BK_DIST_CMP;
      end
      BK_DIST_CMP: begin
        if (dist_sum < cfg_i.dist_limit) begin
          idx_d   = idx_q + CW'(1);
          state_d = BK_SCAN_RD;
        end else begin
          pj_d    = pj_q + PCW'(1);
          state_d = BK_DIST_RD;
        end
      end
      BK_EMIT_RD: begin
        state_d = BK_EMIT_LD;
      end
      BK_EMIT_LD: begin
        if (load) begin
          if (load_last) begin
            count_d   = '0;
            pcount_d  = '0;
            present_d = '0;
            state_d   = BK_COLLECT;
          end else begin
            k_d     = k_q + PCW'(1);
            state_d = BK_EMIT_RD;
          end
        end
      end
      default: state_d = BK_COLLECT;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (pal.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    sat_q  <= sat_d;
    idx_q  <= idx_d;
    cand_q <= cand_d;
    pj_q   <= pj_d;
    k_q    <= k_d;
    sq_r_q <= 16'({8'd0, dr} * {8'd0, dr});
    sq_g_q <= 16'({8'd0, dg} * {8'd0, dg});
    sq_b_q <= 16'({8'd0, db} * {8'd0, db});
    if (load) begin
      if (pcount_q == PCW'(0)) begin
        slot_q  <= 3'd0;
        out_r_q <= 8'd0;
        out_g_q <= 8'd0;
        out_b_q <= 8'd0;
        dk_r_q  <= 8'd0;
        dk_g_q  <= 8'd0;
        dk_b_q  <= 8'd0;
        found_q <= 4'd0;
      end else begin
        slot_q  <= 3'(k_q);
        out_r_q <= pal_rdata[23:16];
        out_g_q <= pal_rdata[15:8];
        out_b_q <= pal_rdata[7:0];
        dk_r_q  <= darken(pal_rdata[23:16], cfg_i.dark_tenths);
        dk_g_q  <= darken(pal_rdata[15:8], cfg_i.dark_tenths);
        dk_b_q  <= darken(pal_rdata[7:0], cfg_i.dark_tenths);
        found_q <= 4'(pcount_q);
      end
      olast_q <= load_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_COLLECT;
      count_q     <= '0;
      present_q   <= '0;
      pcount_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      present_q   <= present_d;
      pcount_q    <= pcount_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign pal.valid        = out_valid_q;
  assign pal.slot         = slot_q;
  assign pal.out_red      = out_r_q;
  assign pal.out_green    = out_g_q;
  assign pal.out_blue     = out_b_q;
  assign pal.dark_red     = dk_r_q;
  assign pal.dark_green   = dk_g_q;
  assign pal.dark_blue    = dk_b_q;
  assign pal.colors_found = found_q;
  assign pal.last_color   = olast_q;

  `VPE_ASSERT_ALWAYS(a_pcount_bound, pcount_q <= PalFull)
  `VPE_ASSERT_ALWAYS(a_count_bound, count_q <= MaxCount)
  `VPE_ASSERT_IMPL(a_no_pop_when_busy, state_q != BK_COLLECT, !pop_o)
  `VPE_ASSERT_NEXT(a_run_clears, load_last, count_q == '0 && pcount_q == '0)
endmodule

// File: tb/vpe_tb_pkg.sv
// Package with the testbench types used by the palette checker.
package vpe_tb_pkg;

  typedef struct packed {
    logic [2:0] slot;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] dk_red;
    logic [7:0] dk_green;
    logic [7:0] dk_blue;
    logic [3:0] found;
    logic       last;
  } palette_entry_t;

endpackage

// File: tb/vpe_tb_ifs.sv
// Interfaces are taken from the RTL; this file holds the configuration write bundle.
interface vpe_cfg_bus_if;
  logic                          we;
  logic [vpe_pkg::CFG_IDX_W-1:0] idx;
  logic [vpe_pkg::CFG_DATA_W-1:0] data;
endinterface

// File: tb/vpe_palette_checker.sv
// Checker that predicts the palette of each image and compares it with the block's output.
module vpe_palette_checker
  import vpe_pkg::*;
  import vpe_tb_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  vpe_pix_if            pix,
  vpe_pal_if            pal,
  vpe_cfg_bus_if        cfg,
  output int            fail_count,
  output int            pending_colours,
  output int            palettes_seen,
  output int            kept_seen
);

  logic [7:0]  min_sat;
  logic [7:0]  min_bri;
  logic [17:0] dist_lim;
  logic [3:0]  dark_k;
  logic [31:0] kept_q[$];
  palette_entry_t expected_colours[$];

  function automatic logic [7:0] darken_chan(logic [7:0] c);
    int unsigned v;
    v = (int'(c) * int'(dark_k)) / 10;
    return (v > 255) ? 8'd255 : v[7:0];
  endfunction

  function automatic logic [7:0] saturation_of(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    int unsigned mx, mn;
    mx = r; mn = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    if (mx == 0) return 8'd0;
    return 8'((510 * (mx - mn) + mx) / (2 * mx));
  endfunction

  task automatic predict_palette();
    logic [23:0] chosen[$];
    int unsigned d, dr, dg, db;
    logic [23:0] c;
    bit distinct;
    int n;
    palette_entry_t e;
    for (int s = 255; s >= 1 && chosen.size() < PALETTE_SIZE_DEF; s--) begin
      foreach (kept_q[i]) begin
        if (kept_q[i][31:24] != s || chosen.size() >= PALETTE_SIZE_DEF) continue;
        c = kept_q[i][23:0];
        distinct = 1;
        foreach (chosen[j]) begin
          dr = (chosen[j][23:16] > c[23:16]) ? chosen[j][23:16] - c[23:16]
                                            : c[23:16] - chosen[j][23:16];
          dg = (chosen[j][15:8] > c[15:8]) ? chosen[j][15:8] - c[15:8]
                                          : c[15:8] - chosen[j][15:8];
          db = (chosen[j][7:0] > c[7:0]) ? chosen[j][7:0] - c[7:0]
                                        : c[7:0] - chosen[j][7:0];
          d = dr * dr + dg * dg + db * db;
          if (d < dist_lim) distinct = 0;
        end
        if (distinct) chosen = {chosen, c};
      end
    end
    n = chosen.size();
    if (n == 0) begin
      e = '0;
      e.last = 1'b1;
      expected_colours = {expected_colours, e};
    end
    for (int k = 0; k < n; k++) begin
      c = chosen[n - 1 - k];
      e.slot = 3'(k);
      e.red = c[23:16];
      e.green = c[15:8];
      e.blue = c[7:0];
      e.dk_red = darken_chan(c[23:16]);
      e.dk_green = darken_chan(c[15:8]);
      e.dk_blue = darken_chan(c[7:0]);
      e.found = 4'(n);
      e.last = (k == n - 1);
      expected_colours = {expected_colours, e};
    end
    kept_q.delete();
  endtask

  palette_entry_t got, want;
  logic [7:0] sat_v, mx_v;
  logic [31:0] kept_word;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_sat <= MIN_SAT_RST;
      min_bri <= MIN_BRI_RST;
      dist_lim <= DIST_LIMIT_RST;
      dark_k <= DARK_RST;
      kept_q.delete();
      expected_colours.delete();
      fail_count <= 0;
      pending_colours <= 0;
      palettes_seen <= 0;
      kept_seen <= 0;
    end else begin
      if (cfg.we) begin
        case (cfg_idx_e'(cfg.idx))
          CFG_MIN_SAT:    min_sat <= cfg.data[7:0];
          CFG_MIN_BRI:    min_bri <= cfg.data[7:0];
          CFG_DIST_LIMIT: dist_lim <= cfg.data;
          CFG_DARK:       dark_k <= cfg.data[3:0];
          default: ;
        endcase
      end
      if (pix.valid && pix.ready) begin
        sat_v = saturation_of(pix.pix_red, pix.pix_green, pix.pix_blue);
        mx_v = pix.pix_red;
        if (pix.pix_green > mx_v) mx_v = pix.pix_green;
        if (pix.pix_blue > mx_v) mx_v = pix.pix_blue;
        if (sat_v >= 1 && sat_v >= min_sat && mx_v >= min_bri
            && kept_q.size() < MAX_PIXELS_DEF) begin
          kept_word = {sat_v, pix.pix_red, pix.pix_green, pix.pix_blue};
          kept_q = {kept_q, kept_word};
          kept_seen <= kept_seen + 1;
        end
        if (pix.last_pixel) predict_palette();
      end
      if (pal.valid && pal.ready) begin
        got = {pal.slot, pal.out_red, pal.out_green, pal.out_blue, pal.dark_red,
               pal.dark_green, pal.dark_blue, pal.colors_found, pal.last_color};
        if (expected_colours.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("unexpected palette transaction %h", got);
        end else begin
          want = expected_colours.pop_front();
          if (got !== want) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("palette mismatch: expected %h, got %h", want, got);
          end
          if (want.last) palettes_seen <= palettes_seen + 1;
        end
      end
      pending_colours <= expected_colours.size();
    end
  end

endmodule

// File: tb/vibrant_palette_extractor_top_tb.sv
// Testbench top: drives images and configuration into the palette extractor and gives the verdict.
module vibrant_palette_extractor_top_tb;
  import vpe_pkg::*;

  logic clk_i;
  logic rst_ni;
  int   fail_count, pending_colours, palettes_seen, kept_seen;
  int   pixels_sent;
  int   hold_cycles;
  int   stall_len;
  bit   long_hold_req;

  vpe_pix_if     pix ();
  vpe_pal_if     pal ();
  vpe_cfg_bus_if cfg ();

  vibrant_palette_extractor_top uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .pix        (pix),
    .pal        (pal),
    .cfg_we_i   (cfg.we),
    .cfg_idx_i  (cfg.idx),
    .cfg_data_i (cfg.data)
  );

  vpe_palette_checker checker_i (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .pix             (pix),
    .pal             (pal),
    .cfg             (cfg),
    .fail_count      (fail_count),
    .pending_colours (pending_colours),
    .palettes_seen   (palettes_seen),
    .kept_seen       (kept_seen)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2000000;
    $display("vibrant_palette_extractor_top_tb failed");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 93) return int'($urandom_range(1, 3));
    return int'($urandom_range(10, 40));
  endfunction

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    pal.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        pal.ready <= 1'b0;
        hold_cycles = 0;
        while (hold_cycles < 4000) begin
          @(posedge clk_i);
          hold_cycles++;
        end
        long_hold_req = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_len = gap_len();
        if (stall_len > 0) begin
          pal.ready <= 1'b0;
          repeat (stall_len) @(posedge clk_i);
        end
      end
      pal.ready <= 1'b1;
    end
  end

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic lst,
                            bit idle_ok);
    int g_n;
    g_n = idle_ok ? gap_len() : 0;
    if (g_n > 0) begin
      pix.valid <= 1'b0;
      repeat (g_n) @(posedge clk_i);
    end
    pix.valid <= 1'b1;
    pix.pix_red <= r;
    pix.pix_green <= g;
    pix.pix_blue <= b;
    pix.last_pixel <= lst;
    do @(posedge clk_i); while (!pix.ready);
    pixels_sent++;
  endtask

  task automatic drain();
    pix.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_colours != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [17:0] value);
    cfg.we <= 1'b1;
    cfg.idx <= idx;
    cfg.data <= value;
    @(posedge clk_i);
    cfg.we <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random image: colours near red or green, random colours, and some grey or dark noise.
  task automatic send_image(int npix, bit idle_ok);
    logic [7:0] r, g, b;
    for (int i = 0; i < npix; i++) begin
      case ($urandom_range(0, 5))
        0: begin r = 8'($urandom); g = r; b = r; end
        1: begin r = 8'($urandom_range(0, 40)); g = 8'($urandom_range(0, 40));
                 b = 8'($urandom_range(0, 40)); end
        2: begin r = 8'hff; g = 8'($urandom_range(0, 60)); b = 8'($urandom_range(0, 60)); end
        3: begin r = 8'($urandom_range(0, 60)); g = 8'hff; b = 8'($urandom_range(0, 60)); end
        default: begin r = 8'($urandom); g = 8'($urandom); b = 8'($urandom); end
      endcase
      send_pixel(r, g, b, i == npix - 1, idle_ok);
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    long_hold_req = 0;
    pixels_sent = 0;
    pix.valid = 1'b0;
    pix.pix_red = '0;
    pix.pix_green = '0;
    pix.pix_blue = '0;
    pix.last_pixel = 1'b0;
    cfg.we = 1'b0;
    cfg.idx = CFG_MIN_SAT;
    cfg.data = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, extremes, grey, black, ties and an empty palette.
    send_pixel(8'hff, 8'h00, 8'h00, 1'b0, 1'b0);
    send_pixel(8'h00, 8'hff, 8'h00, 1'b0, 1'b0);
    send_pixel(8'h00, 8'h00, 8'hff, 1'b0, 1'b0);
    send_pixel(8'hff, 8'hff, 8'hff, 1'b0, 1'b0);
    send_pixel(8'h00, 8'h00, 8'h00, 1'b0, 1'b0);
    send_pixel(8'hfe, 8'h01, 8'h02, 1'b0, 1'b0);
    send_pixel(8'h80, 8'h40, 8'h40, 1'b0, 1'b0);
    send_pixel(8'h80, 8'h41, 8'h40, 1'b0, 1'b0);
    send_pixel(8'h31, 8'h00, 8'h00, 1'b0, 1'b0);
    send_pixel(8'h55, 8'haa, 8'hff, 1'b1, 1'b0);
    drain();
    send_pixel(8'h10, 8'h10, 8'h10, 1'b1, 1'b0);
    drain();
    write_reg(CFG_MIN_SAT, 18'd0);
    write_reg(CFG_MIN_BRI, 18'd0);
    write_reg(CFG_DIST_LIMIT, 18'd0);
    write_reg(CFG_DARK, 18'd15);
    for (int i = 0; i < 10; i++)
      send_pixel(8'(i * 25), 8'hff - 8'(i), 8'(i), i == 9, 1'b0);
    drain();

    // Random images, with settings swept between phases.
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_MIN_SAT, ph == 1 ? 18'd255 : 18'($urandom_range(0, 120)));
      write_reg(CFG_MIN_BRI, ph == 2 ? 18'd255 : 18'($urandom_range(0, 120)));
      write_reg(CFG_DIST_LIMIT, ph == 3 ? 18'd195075 :
                ph == 4 ? 18'h3ffff : 18'($urandom_range(0, 20000)));
      write_reg(CFG_DARK, ph == 5 ? 18'd0 : ph == 6 ? 18'd10 : 18'($urandom_range(0, 15)));
      for (int im = 0; im < 3; im++) begin
        if (ph == 4 && im == 0) long_hold_req = 1;
        send_image(int'($urandom_range(4, 22)), ph != 7);
      end
      drain();
    end
    write_reg(CFG_MIN_SAT, 18'd30);
    write_reg(CFG_MIN_BRI, 18'd50);
    write_reg(CFG_DIST_LIMIT, 18'd900);
    write_reg(CFG_DARK, 18'd7);
    send_image(12, 1'b1);
    drain();

    $display("Sent %0d pixels in %0d images; %0d pixels were kept.",
             pixels_sent, palettes_seen, kept_seen);
    if (fail_count == 0) begin
      $display("vibrant_palette_extractor_top_tb passed");
    end else begin
      $display("vibrant_palette_extractor_top_tb failed");
    end
    $finish;
  end

endmodule
